// ----- rtl/core/frq_pkg.sv -----
// Shared types and constants for the frame ring overwrite queue.
package frq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int FILL_W = 5;

  localparam logic [2:0] ACT_PUSH       = 3'd0;
  localparam logic [2:0] ACT_POP_LATEST = 3'd1;
  localparam logic [2:0] ACT_POP_NEXT   = 3'd2;
  localparam logic [2:0] ACT_UPLOAD     = 3'd3;
  localparam logic [2:0] ACT_CLEAR      = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        frame_handle;
    logic               frame_present;
    logic [31:0]        frame_num;
    logic signed [63:0] decode_stamp;
    logic signed [63:0] now_ts;
    logic signed [63:0] upload_stamp;
  } in_item_t;

  typedef struct packed {
    logic               taken;
    logic [31:0]        out_handle;
    logic               out_present;
    logic [31:0]        out_frame_num;
    logic signed [63:0] last_decode_stamp;
    logic signed [63:0] last_enqueue_ts;
    logic signed [63:0] last_upload_stamp;
    logic [FILL_W-1:0]  fill_count;
    logic [31:0]        dropped_total;
    logic [31:0]        pushed_total;
    logic [31:0]        popped_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] handle;
    logic        present;
    logic [31:0] frame_num;
    logic [63:0] decode_time;
    logic [63:0] enqueue_time;
  } slot_t;

endpackage

// ----- rtl/core/frq_slot_ram.sv -----
// Slot descriptor memory with one write port and a registered read port.
module frq_slot_ram
  import frq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  slot_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output slot_t            rdata
);

  slot_t mem [DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/frame_ring_overwrite_queue.sv -----
// Top level of the frame ring overwrite queue.
//
// Items arrive on the in_ channel and each produces exactly one result on the
// out_ channel; both use a valid/ready transfer. A push stores a descriptor
// and overwrites the oldest one when the ring is full. Pop next returns the
// oldest descriptor, pop latest returns the newest one and empties the ring.
// The cfg_ channel writes the ring capacity (0 or above DEPTH selects DEPTH)
// and empties the ring; it is written only while the block is idle.
// The slot memory is read when an item is accepted; the state update and the
// output register load follow in the execute state. A new item is accepted
// only after the previous one has left the execute state, since the memory
// read and the state update of one item never overlap the next.
// If the receiver stalls, one result waits in the output register while the
// next item is accepted and read; that item then waits until the output
// register frees. Reset empties the ring and clears the held metrics and the
// counters; slot memory contents are not cleared and need no clearing pass.
module frame_ring_overwrite_queue
  import frq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [IDX_W-1:0]   raddr_r, raddr_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [31:0]        held_id_r, held_id_nxt;
  logic [63:0]        held_dec_r, held_dec_nxt;
  logic [63:0]        held_enq_r, held_enq_nxt;
  logic [63:0]        held_upl_r, held_upl_nxt;
  logic [31:0]        drop_r, drop_nxt;
  logic [31:0]        push_r, push_nxt;
  logic [31:0]        pop_r, pop_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_xfer;
  logic               cfg_xfer;
  logic               exec_go;
  logic [IDX_W-1:0]   newest;
  logic [CNT_W-1:0]   rd_inc;
  logic [CNT_W-1:0]   wr_inc;
  logic [IDX_W-1:0]   rd_adv;
  logic [IDX_W-1:0]   wr_adv;
  logic               ram_we;
  slot_t              ram_wdata;
  slot_t              ram_rdata;
  logic               taken;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign newest = (wr_idx_r == '0) ? IDX_W'(cap_r - CNT_W'(1)) : wr_idx_r - IDX_W'(1);
  assign rd_inc = CNT_W'(rd_idx_r) + CNT_W'(1);
  assign wr_inc = CNT_W'(wr_idx_r) + CNT_W'(1);
  assign rd_adv = (rd_inc >= cap_r) ? '0 : rd_inc[IDX_W-1:0];
  assign wr_adv = (wr_inc >= cap_r) ? '0 : wr_inc[IDX_W-1:0];

  assign ram_we = exec_go && (item_r.action == ACT_PUSH);
  always_comb begin
    ram_wdata.handle       = item_r.frame_handle;
    ram_wdata.present      = item_r.frame_present;
    ram_wdata.frame_num    = item_r.frame_present ? item_r.frame_num : 32'd0;
    ram_wdata.decode_time  = item_r.decode_stamp;
    ram_wdata.enqueue_time = item_r.now_ts;
  end

  always_comb begin
    raddr_nxt = raddr_r;
    item_nxt  = item_r;
    if (in_xfer) begin
      item_nxt = in_data;
      if (in_data.action == ACT_POP_LATEST) begin
        raddr_nxt = newest;
      end else begin
        raddr_nxt = rd_idx_r;
      end
    end
  end

  frq_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .raddr (raddr_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    occ_nxt       = occ_r;
    held_id_nxt   = held_id_r;
    held_dec_nxt  = held_dec_r;
    held_enq_nxt  = held_enq_r;
    held_upl_nxt  = held_upl_r;
    drop_nxt      = drop_r;
    push_nxt      = push_r;
    pop_nxt       = pop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    taken         = 1'b0;

    if (cfg_xfer) begin
      if (cfg_data == '0 || int'(cfg_data) > DEPTH) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_data);
      end
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      occ_nxt    = '0;
    end

    if (in_xfer) begin
      state_nxt = S_EXEC;
    end

    if (exec_go) begin
      state_nxt = S_IDLE;
      case (item_r.action)
        ACT_PUSH: begin
          if (occ_r >= cap_r) begin
            rd_idx_nxt = rd_adv;
            drop_nxt   = drop_r + 32'd1;
          end else begin
            occ_nxt = occ_r + CNT_W'(1);
          end
          wr_idx_nxt = wr_adv;
          push_nxt   = push_r + 32'd1;
        end
        ACT_POP_LATEST: begin
          if (occ_r != '0) begin
            taken      = 1'b1;
            drop_nxt   = drop_r + 32'(occ_r - CNT_W'(1));
            rd_idx_nxt = wr_idx_r;
            occ_nxt    = '0;
          end
        end
        ACT_POP_NEXT: begin
          if (occ_r != '0) begin
            taken      = 1'b1;
            rd_idx_nxt = rd_adv;
            occ_nxt    = occ_r - CNT_W'(1);
          end
        end
        ACT_UPLOAD: begin
          held_upl_nxt = item_r.upload_stamp;
        end
        ACT_CLEAR: begin
          drop_nxt = '0;
          push_nxt = '0;
          pop_nxt  = '0;
        end
        default: begin
        end
      endcase

      if (taken) begin
        held_id_nxt  = ram_rdata.frame_num;
        held_dec_nxt = ram_rdata.decode_time;
        held_enq_nxt = ram_rdata.enqueue_time;
        held_upl_nxt = '0;
        pop_nxt      = pop_r + 32'd1;
      end

      out_valid_nxt             = 1'b1;
      out_nxt.taken             = taken;
      out_nxt.out_handle        = taken ? ram_rdata.handle : 32'd0;
      out_nxt.out_present       = taken && ram_rdata.present;
      out_nxt.out_frame_num     = held_id_nxt;
      out_nxt.last_decode_stamp = held_dec_nxt;
      out_nxt.last_enqueue_ts   = held_enq_nxt;
      out_nxt.last_upload_stamp = held_upl_nxt;
      out_nxt.fill_count        = FILL_W'(occ_nxt);
      out_nxt.dropped_total     = drop_nxt;
      out_nxt.pushed_total      = push_nxt;
      out_nxt.popped_total      = pop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= (DEPTH < 16) ? CNT_W'(DEPTH) : CNT_W'(16);
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      occ_r       <= '0;
      held_id_r   <= '0;
      held_dec_r  <= '0;
      held_enq_r  <= '0;
      held_upl_r  <= '0;
      drop_r      <= '0;
      push_r      <= '0;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      occ_r       <= occ_nxt;
      held_id_r   <= held_id_nxt;
      held_dec_r  <= held_dec_nxt;
      held_enq_r  <= held_enq_nxt;
      held_upl_r  <= held_upl_nxt;
      drop_r      <= drop_nxt;
      push_r      <= push_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r  <= item_nxt;
    raddr_r <= raddr_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
